[hw/rtl/utrds_pkg.sv]
package utrds_pkg;

   localparam int Q_DEPTH = 256;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);
   // width wide enough to compare queue counts with 9-bit message fields
   localparam int CMP_W   = (Q_CW > 9) ? Q_CW : 9;
   localparam int SUM_W   = Q_CW + 1;

   localparam logic [8:0] MAX_CHUNK_RESET = 9'd64;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_STEP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_SEND  = 3'd1,
      ST_BUSY  = 3'd2,
      ST_DONE  = 3'd3,
      ST_ERROR = 3'd4
   } state_type;

   typedef enum logic [1:0] {
      EV_NONE         = 2'd0,
      EV_DMA_COMPLETE = 2'd1,
      EV_DMA_ERROR    = 2'd2,
      EV_UART_FREE    = 2'd3
   } event_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic       first_of_message;
      logic [8:0] message_len;
      logic [1:0] event_req;
   } req_type;

   typedef struct packed {
      logic [2:0] fsm_state;
      logic       push_accepted;
      logic       dma_start;
      logic [7:0] dma_index;
      logic [8:0] dma_length;
      logic       dma_stop;
      logic [8:0] queue_used;
   } rsp_type;

endpackage

[hw/rtl/uart_tx_ring_dma_scheduler.sv]
// UART transmit ring queue with DMA transfer scheduling.
// req channel (valid/ready) carries one item per transfer: mode 0 pushes a
// message byte into the ring, mode 1 steps the idle/send/busy/done/error
// machine and may bring a dma or uart event that is latched first.
// rsp channel (valid/ready) returns exactly one result per item: machine
// state, push acceptance, dma start/index/length, dma stop and queue fill.
// csr_wr_en/csr_wr_data write max_chunk (reset 64), the transfer size cap;
// write it only while no item is in flight.
// The result is registered: it is in the output register on the cycle
// after the request transfer. Throughput is one item per cycle while the
// receiver keeps up, set by the single pass of counter logic and one ring
// write between request and the output register.
// A stalled receiver holds the result in the output register; req_ready
// stays high while that register is empty or being drained in the same
// cycle, so the block blocks only as long as rsp_ready is low.
// Synchronous reset empties the ring, returns the machine to idle, clears
// the latched event and restores max_chunk to 64. Ring contents are not
// cleared, nothing reads a slot before it is written.
module uart_tx_ring_dma_scheduler (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  utrds_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output utrds_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [8:0]         csr_wr_data
);

   logic               req_fire;
   logic               rsp_valid_ff, rsp_valid_in;
   utrds_pkg::rsp_type rsp_data_ff;
   utrds_pkg::rsp_type result;
   logic [8:0]         max_chunk_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   utrds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .item_valid(req_fire),
      .item      (req_data),
      .max_chunk (max_chunk_ff),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         max_chunk_ff <= utrds_pkg::MAX_CHUNK_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_chunk_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[hw/rtl/utrds_ram.sv]
module utrds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/utrds_ctrl.sv]
module utrds_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  utrds_pkg::req_type item,
   input  logic [8:0]         max_chunk,
   output utrds_pkg::rsp_type result
);

   logic [utrds_pkg::Q_AW-1:0]  rd_pos_ff, rd_pos_in;
   logic [utrds_pkg::Q_CW-1:0]  used_ff, used_in;
   utrds_pkg::state_type        state_ff, state_in;
   utrds_pkg::event_type        event_ff, event_in;
   logic [utrds_pkg::Q_CW-1:0]  chunk_ff, chunk_in;
   logic                        open_ff, open_in;
   logic [8:0]                  left_ff, left_in;

   logic [utrds_pkg::Q_CW-1:0]  free_cnt;
   logic [utrds_pkg::SUM_W-1:0] slot_sum;
   logic [utrds_pkg::Q_AW-1:0]  slot;
   logic                        too_big;
   logic                        wr_en;

   logic [utrds_pkg::Q_CW-1:0]  run_tail;
   logic [utrds_pkg::Q_CW-1:0]  run_avail;
   logic [8:0]                  cap;
   logic [utrds_pkg::CMP_W-1:0] run_len;

   logic [utrds_pkg::Q_CW-1:0]  chunk_eff;
   logic [utrds_pkg::SUM_W-1:0] adv_sum;
   logic [utrds_pkg::Q_AW-1:0]  adv_pos;

   utrds_pkg::event_type        ev_now;
   logic                        open_v;
   logic [8:0]                  left_v;
   logic                        drop;
   logic                        accepted, start, stop;

   // push side
   assign free_cnt = utrds_pkg::Q_CW'(utrds_pkg::Q_DEPTH) - used_ff;
   assign too_big  = utrds_pkg::CMP_W'(item.message_len) > utrds_pkg::CMP_W'(free_cnt);
   assign slot_sum = utrds_pkg::SUM_W'(rd_pos_ff) + utrds_pkg::SUM_W'(used_ff);
   assign slot     = (slot_sum >= utrds_pkg::SUM_W'(utrds_pkg::Q_DEPTH))
                     ? utrds_pkg::Q_AW'(slot_sum - utrds_pkg::SUM_W'(utrds_pkg::Q_DEPTH))
                     : utrds_pkg::Q_AW'(slot_sum);

   // contiguous readable run, capped
   assign run_tail  = utrds_pkg::Q_CW'(utrds_pkg::Q_DEPTH) - utrds_pkg::Q_CW'(rd_pos_ff);
   assign run_avail = (used_ff < run_tail) ? used_ff : run_tail;
   assign cap       = (max_chunk == 9'd0) ? 9'd1 : max_chunk;
   assign run_len   = (utrds_pkg::CMP_W'(run_avail) > utrds_pkg::CMP_W'(cap))
                      ? utrds_pkg::CMP_W'(cap) : utrds_pkg::CMP_W'(run_avail);

   // freeing on done
   assign chunk_eff = (chunk_ff > used_ff) ? used_ff : chunk_ff;
   assign adv_sum   = utrds_pkg::SUM_W'(rd_pos_ff) + utrds_pkg::SUM_W'(chunk_eff);
   assign adv_pos   = (adv_sum >= utrds_pkg::SUM_W'(utrds_pkg::Q_DEPTH))
                      ? utrds_pkg::Q_AW'(adv_sum - utrds_pkg::SUM_W'(utrds_pkg::Q_DEPTH))
                      : utrds_pkg::Q_AW'(adv_sum);

   always_comb begin
      rd_pos_in = rd_pos_ff;
      used_in   = used_ff;
      state_in  = state_ff;
      event_in  = event_ff;
      chunk_in  = chunk_ff;
      open_in   = open_ff;
      left_in   = left_ff;
      wr_en     = 1'b0;
      accepted  = 1'b0;
      start     = 1'b0;
      stop      = 1'b0;
      open_v    = open_ff;
      left_v    = left_ff;
      drop      = 1'b0;
      ev_now    = event_ff;
      if (item_valid && item.mode == utrds_pkg::MODE_PUSH) begin
         if (item.first_of_message) begin
            if (item.message_len == 9'd0 || too_big) begin
               open_v = 1'b0;
               left_v = 9'd0;
               drop   = 1'b1;
            end else begin
               open_v = 1'b1;
               left_v = item.message_len;
            end
         end
         if (!drop && open_v && left_v != 9'd0 &&
             used_ff < utrds_pkg::Q_CW'(utrds_pkg::Q_DEPTH)) begin
            wr_en    = 1'b1;
            accepted = 1'b1;
            used_in  = used_ff + 1'b1;
            left_v   = left_v - 9'd1;
            if (left_v == 9'd0) begin
               open_v = 1'b0;
            end
         end
         open_in = open_v;
         left_in = left_v;
      end else if (item_valid) begin
         // a new event replaces the latch before the machine looks at it
         if (utrds_pkg::event_type'(item.event_req) != utrds_pkg::EV_NONE) begin
            ev_now = utrds_pkg::event_type'(item.event_req);
         end
         event_in = ev_now;
         case (state_ff)
            utrds_pkg::ST_IDLE: begin
               if (used_ff != '0) begin
                  state_in = utrds_pkg::ST_SEND;
               end
            end
            utrds_pkg::ST_SEND: begin
               chunk_in = utrds_pkg::Q_CW'(run_len);
               start    = 1'b1;
               event_in = utrds_pkg::EV_NONE;
               state_in = utrds_pkg::ST_BUSY;
            end
            utrds_pkg::ST_BUSY: begin
               if (ev_now == utrds_pkg::EV_DMA_ERROR) begin
                  state_in = utrds_pkg::ST_ERROR;
               end else if (ev_now == utrds_pkg::EV_DMA_COMPLETE ||
                            ev_now == utrds_pkg::EV_UART_FREE) begin
                  state_in = utrds_pkg::ST_DONE;
               end
            end
            utrds_pkg::ST_DONE: begin
               stop      = 1'b1;
               rd_pos_in = adv_pos;
               used_in   = used_ff - chunk_eff;
               chunk_in  = '0;
               if (ev_now == utrds_pkg::EV_UART_FREE) begin
                  state_in = utrds_pkg::ST_IDLE;
               end
            end
            default: begin
               state_in = utrds_pkg::ST_ERROR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pos_ff <= '0;
         used_ff   <= '0;
         state_ff  <= utrds_pkg::ST_IDLE;
         event_ff  <= utrds_pkg::EV_NONE;
         chunk_ff  <= '0;
         open_ff   <= 1'b0;
         left_ff   <= 9'd0;
      end else begin
         rd_pos_ff <= rd_pos_in;
         used_ff   <= used_in;
         state_ff  <= state_in;
         event_ff  <= event_in;
         chunk_ff  <= chunk_in;
         open_ff   <= open_in;
         left_ff   <= left_in;
      end
   end

   utrds_ram #(
      .WIDTH(8),
      .DEPTH(utrds_pkg::Q_DEPTH)
   ) u_queue_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(slot),
      .wr_data(item.data_byte),
      .rd_addr(rd_pos_ff),
      .rd_data()
   );

   always_comb begin
      result.fsm_state     = state_in;
      result.push_accepted = accepted;
      result.dma_start     = start;
      result.dma_index     = start ? 8'(rd_pos_ff) : 8'd0;
      result.dma_length    = start ? 9'(run_len) : 9'd0;
      result.dma_stop      = stop;
      result.queue_used    = 9'(used_in);
   end

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= utrds_pkg::Q_CW'(utrds_pkg::Q_DEPTH))
      else $error("queue fill beyond depth");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff == utrds_pkg::ST_ERROR |=> state_ff == utrds_pkg::ST_ERROR)
      else $error("left error state");

   a_send_clears_event: assert property (@(posedge clock) disable iff (reset)
      item_valid && item.mode == utrds_pkg::MODE_STEP && state_ff == utrds_pkg::ST_SEND
      |=> state_ff == utrds_pkg::ST_BUSY && event_ff == utrds_pkg::EV_NONE)
      else $error("dma start did not clear latched event");

   a_done_frees_once: assert property (@(posedge clock) disable iff (reset)
      item_valid && item.mode == utrds_pkg::MODE_STEP && state_ff == utrds_pkg::ST_DONE
      |=> chunk_ff == '0)
      else $error("chunk not cleared after freeing");

endmodule

[tb/uart_tx_ring_dma_scheduler_test.sv]
module uart_tx_ring_dma_scheduler_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TRAFFIC_ITEMS = 640;
   localparam int PHASE_ITEMS   = 110;
   localparam int QUIET_LIMIT   = 2000;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   utrds_pkg::req_type  req_data    = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   utrds_pkg::rsp_type  rsp_data;
   logic                csr_wr_en   = 1'b0;
   logic [8:0]          csr_wr_data = '0;

   // shadow of the scheduler state
   utrds_pkg::state_type fsm_model  = utrds_pkg::ST_IDLE;
   utrds_pkg::event_type held_event = utrds_pkg::EV_NONE;
   int        head       = 0;
   int        fill       = 0;
   int        inflight   = 0;
   int        msg_left   = 0;
   int        chunk_cap  = int'(utrds_pkg::MAX_CHUNK_RESET);
   bit        msg_open   = 1'b0;

   utrds_pkg::rsp_type expected_status[$];
   utrds_pkg::rsp_type want_status;
   int        error_count  = 0;
   int        items_sent   = 0;
   int        quiet_cycles = 0;
   int        burst_left   = 0;
   bit        sender_gaps  = 1'b1;
   int        rx_hold      = 0;
   int        phase        = 0;
   int        next_phase   = 0;

   uart_tx_ring_dma_scheduler uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic utrds_pkg::rsp_type advance_ring_model(input utrds_pkg::req_type item);
      utrds_pkg::rsp_type r;
      int      run;
      int      cap;
      r = '0;
      if (item.mode == utrds_pkg::MODE_PUSH) begin
         if (item.first_of_message) begin
            if (item.message_len == 0 || item.message_len > utrds_pkg::Q_DEPTH - fill) begin
               msg_open = 1'b0;
               msg_left = 0;
            end else begin
               msg_open = 1'b1;
               msg_left = int'(item.message_len);
            end
         end
         if (msg_open && msg_left > 0 && fill < utrds_pkg::Q_DEPTH) begin
            fill++;
            msg_left--;
            if (msg_left == 0) msg_open = 1'b0;
            r.push_accepted = 1'b1;
         end
      end else begin
         // event lands in the latch before the machine moves
         if (utrds_pkg::event_type'(item.event_req) != utrds_pkg::EV_NONE)
            held_event = utrds_pkg::event_type'(item.event_req);
         case (fsm_model)
            utrds_pkg::ST_IDLE: begin
               if (fill > 0) fsm_model = utrds_pkg::ST_SEND;
            end
            utrds_pkg::ST_SEND: begin
               run = utrds_pkg::Q_DEPTH - head;
               if (fill < run) run = fill;
               cap = (chunk_cap == 0) ? 1 : chunk_cap;
               if (run > cap) run = cap;
               inflight     = run;
               r.dma_start  = 1'b1;
               r.dma_index  = head[7:0];
               r.dma_length = run[8:0];
               held_event   = utrds_pkg::EV_NONE;
               fsm_model    = utrds_pkg::ST_BUSY;
            end
            utrds_pkg::ST_BUSY: begin
               if (held_event == utrds_pkg::EV_DMA_ERROR) fsm_model = utrds_pkg::ST_ERROR;
               else if (held_event == utrds_pkg::EV_DMA_COMPLETE ||
                        held_event == utrds_pkg::EV_UART_FREE)
                  fsm_model = utrds_pkg::ST_DONE;
            end
            utrds_pkg::ST_DONE: begin
               r.dma_stop = 1'b1;
               if (inflight > fill) inflight = fill;
               head     = (head + inflight) % utrds_pkg::Q_DEPTH;
               fill     = fill - inflight;
               inflight = 0;
               if (held_event == utrds_pkg::EV_UART_FREE) fsm_model = utrds_pkg::ST_IDLE;
            end
            default: fsm_model = utrds_pkg::ST_ERROR;
         endcase
      end
      r.fsm_state  = fsm_model;
      r.queue_used = fill[8:0];
      return r;
   endfunction

   function automatic utrds_pkg::req_type push_item(input logic [7:0] data,
                                                    input logic first,
                                                    input logic [8:0] len);
      utrds_pkg::req_type item;
      item.mode             = utrds_pkg::MODE_PUSH;
      item.data_byte        = data;
      item.first_of_message = first;
      item.message_len      = len;
      item.event_req        = 2'($urandom_range(0, 3));
      return item;
   endfunction

   function automatic utrds_pkg::req_type step_item(input utrds_pkg::event_type ev);
      utrds_pkg::req_type item;
      item.mode             = utrds_pkg::MODE_STEP;
      item.data_byte        = 8'($urandom_range(0, 255));
      item.first_of_message = 1'($urandom_range(0, 1));
      item.message_len      = 9'($urandom_range(0, 511));
      item.event_req        = ev;
      return item;
   endfunction

   // keeps the machine out of the sticky error state during random traffic
   function automatic utrds_pkg::event_type step_event();
      int                   roll;
      utrds_pkg::event_type ev;
      roll = $urandom_range(0, 99);
      if (fsm_model == utrds_pkg::ST_BUSY) begin
         if (roll < 40) ev = utrds_pkg::EV_NONE;
         else if (roll < 70) ev = utrds_pkg::EV_DMA_COMPLETE;
         else ev = utrds_pkg::EV_UART_FREE;
      end else if (fsm_model == utrds_pkg::ST_DONE) begin
         if (roll < 55) ev = utrds_pkg::EV_UART_FREE;
         else if (roll < 80) ev = utrds_pkg::EV_NONE;
         else if (roll < 90) ev = utrds_pkg::EV_DMA_COMPLETE;
         else ev = utrds_pkg::EV_DMA_ERROR;
      end else begin
         ev = utrds_pkg::event_type'(roll % 4);
      end
      return ev;
   endfunction

   task automatic send_req(input utrds_pkg::req_type item);
      int gap;
      @(negedge clock);
      if (sender_gaps && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      expected_status.push_back(advance_ring_model(item));
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_max_chunk(input logic [8:0] value);
      drain_results();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      chunk_cap = int'(value);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            $error("unexpected result transfer: %p", rsp_data);
            error_count++;
         end else begin
            want_status = expected_status.pop_front();
            check_field("fsm_state", want_status.fsm_state, rsp_data.fsm_state);
            check_field("push_accepted", want_status.push_accepted, rsp_data.push_accepted);
            check_field("dma_start", want_status.dma_start, rsp_data.dma_start);
            check_field("dma_index", want_status.dma_index, rsp_data.dma_index);
            check_field("dma_length", want_status.dma_length, rsp_data.dma_length);
            check_field("dma_stop", want_status.dma_stop, rsp_data.dma_stop);
            check_field("queue_used", want_status.queue_used, rsp_data.queue_used);
         end
      end
   end

   // receiver: short stalls, now and then a long stretch of steady ready
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rx_hold--;
      end else if (rsp_ready) begin
         rsp_ready <= 1'b0;
         rx_hold = $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
         rx_hold = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90) : $urandom_range(0, 10);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic test_idle_and_drops();
      send_req(step_item(utrds_pkg::EV_NONE));   // idle with an empty ring stays idle
      send_req(push_item(8'h3C, 1'b0, 9'd5));    // stray byte, no open message
      send_req(push_item(8'h00, 1'b1, 9'd0));    // zero length message
      send_req(push_item(8'hFF, 1'b1, 9'd511));  // too large
      send_req(push_item(8'h81, 1'b0, 9'd511));
   endtask

   task automatic test_transfer_cycle();
      write_max_chunk(9'd0);                     // zero cap behaves as one
      send_req(push_item(8'hFF, 1'b1, 9'd2));
      send_req(push_item(8'h00, 1'b0, 9'd0));
      send_req(push_item(8'h55, 1'b0, 9'd2));    // length used up
      send_req(push_item(8'hAA, 1'b1, 9'd256));  // more than free space
      send_req(push_item(8'h12, 1'b1, 9'd3));
      send_req(push_item(8'h34, 1'b0, 9'd3));
      send_req(push_item(8'h56, 1'b1, 9'd1));    // new message closes the open one
      send_req(step_item(utrds_pkg::EV_UART_FREE));
      send_req(step_item(utrds_pkg::EV_DMA_ERROR)); // latched, then cleared by the start
      send_req(step_item(utrds_pkg::EV_NONE));
      send_req(step_item(utrds_pkg::EV_DMA_COMPLETE));
      send_req(step_item(utrds_pkg::EV_NONE));
      send_req(step_item(utrds_pkg::EV_NONE));   // second done step frees nothing
      send_req(step_item(utrds_pkg::EV_UART_FREE));
      write_max_chunk(9'd256);
      send_req(step_item(utrds_pkg::EV_NONE));
      send_req(step_item(utrds_pkg::EV_NONE));
      send_req(step_item(utrds_pkg::EV_UART_FREE));
      send_req(step_item(utrds_pkg::EV_UART_FREE));
   endtask

   task automatic test_random_traffic(input int stop_at);
      int                 roll;
      int                 len;
      int                 follow;
      int unsigned        raw;
      utrds_pkg::req_type noise;
      while (items_sent < stop_at) begin
         if (items_sent >= next_phase) begin
            next_phase = items_sent + PHASE_ITEMS;
            case (phase)
               0: write_max_chunk(9'($urandom_range(2, 16)));
               1: write_max_chunk(9'd1);
               2: write_max_chunk(9'd256);
               3: write_max_chunk(9'd511);
               default: write_max_chunk(9'($urandom_range(1, 40)));
            endcase
            sender_gaps = (phase % 3 != 1);
            phase++;
         end
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) len = $urandom_range(1, 12);
            else if (roll < 90) len = $urandom_range(13, 48);
            else if (roll < 94) len = $urandom_range(49, 256);
            else if (roll < 97) len = 0;
            else len = $urandom_range(257, 511);
            follow = (len > 0 && len <= utrds_pkg::Q_DEPTH) ? len - 1 : $urandom_range(0, 2);
            roll = $urandom_range(0, 9);
            if (roll == 0 && follow > 0) follow = $urandom_range(0, follow - 1);
            else if (roll == 1) follow += $urandom_range(1, 3);
            if (follow > 60) follow = 60;
            send_req(push_item(8'($urandom_range(0, 255)), 1'b1, len[8:0]));
            repeat (follow)
               send_req(push_item(8'($urandom_range(0, 255)), 1'b0,
                                  9'($urandom_range(0, 511))));
         end else if (roll < 85) begin
            repeat ($urandom_range(1, 8)) send_req(step_item(step_event()));
         end else begin
            raw   = $urandom;
            noise = raw[$bits(utrds_pkg::req_type)-1:0];
            if (noise.mode == utrds_pkg::MODE_STEP) noise.event_req = step_event();
            send_req(noise);
         end
      end
   endtask

   task automatic test_ring_full();
      int room;
      room = utrds_pkg::Q_DEPTH - fill;
      if (room > 0) begin
         send_req(push_item(8'($urandom_range(0, 255)), 1'b1, room[8:0]));
         repeat (room - 1) send_req(push_item(8'($urandom_range(0, 255)), 1'b0, 9'd0));
      end
      // nothing fits in a full ring
      send_req(push_item(8'hA5, 1'b1, 9'd1));
      send_req(push_item(8'h5A, 1'b0, 9'd1));
   endtask

   task automatic test_error_sticky();
      while (fsm_model != utrds_pkg::ST_BUSY) begin
         if (fsm_model == utrds_pkg::ST_IDLE && fill == 0)
            send_req(push_item(8'h77, 1'b1, 9'd1));
         else if (fsm_model == utrds_pkg::ST_DONE)
            send_req(step_item(utrds_pkg::EV_UART_FREE));
         else
            send_req(step_item(utrds_pkg::EV_NONE));
      end
      send_req(step_item(utrds_pkg::EV_DMA_ERROR));
      send_req(step_item(utrds_pkg::EV_UART_FREE));
      send_req(step_item(utrds_pkg::EV_DMA_COMPLETE));
      send_req(step_item(utrds_pkg::EV_NONE));
      send_req(push_item(8'hC3, 1'b1, 9'd1));
      send_req(step_item(utrds_pkg::EV_UART_FREE));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_idle_and_drops();
      test_transfer_cycle();
      test_random_traffic(TRAFFIC_ITEMS / 2);
      test_ring_full();
      test_random_traffic(TRAFFIC_ITEMS);
      test_error_sticky();
      drain_results();
      repeat (4) @(posedge clock);
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

[uart_tx_ring_dma_scheduler.f]
hw/rtl/utrds_pkg.sv
hw/rtl/utrds_ram.sv
hw/rtl/utrds_ctrl.sv
hw/rtl/uart_tx_ring_dma_scheduler.sv
tb/uart_tx_ring_dma_scheduler_test.sv
